>>> rtl/core/ame_pkg.sv
// Shared types, constants and helpers for the accumulator machine execute block.
// No dependencies; every other file in rtl/core except ame_ram imports this package.
package ame_pkg;

    localparam int REG_COUNT_DEF = 19;
    localparam int MEM_DEPTH_DEF = 64;
    localparam int PROG_DEPTH    = 1024;
    localparam int QUEUE_DEPTH   = 2;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;
    localparam int OP_W   = 4;
    localparam int KIND_W = 2;
    localparam int TGT_W  = 10;
    localparam int STAT_W = 2;

    localparam logic [OP_W-1:0] OP_NOP = 4'd0;
    localparam logic [OP_W-1:0] OP_MOV = 4'd1;
    localparam logic [OP_W-1:0] OP_CMP = 4'd2;
    localparam logic [OP_W-1:0] OP_BRH = 4'd3;
    localparam logic [OP_W-1:0] OP_BEQ = 4'd4;
    localparam logic [OP_W-1:0] OP_OUT = 4'd5;
    localparam logic [OP_W-1:0] OP_ADD = 4'd6;
    localparam logic [OP_W-1:0] OP_SUB = 4'd7;
    localparam logic [OP_W-1:0] OP_MLT = 4'd8;
    localparam logic [OP_W-1:0] OP_DIV = 4'd9;

    localparam logic [KIND_W-1:0] KIND_IMM = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MEM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REG = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DIVZ = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

    // Classified instruction as it travels from front to back.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KIND_W-1:0] a_kind;
        logic [IDX_W-1:0]  a_index;
        logic [DATA_W-1:0] a_imm;
        logic [KIND_W-1:0] b_kind;
        logic [IDX_W-1:0]  b_index;
        logic [DATA_W-1:0] b_imm;
        logic [TGT_W-1:0]  target;
        logic              bad;
        logic              tgt_ok;
    } ame_dec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ame_qstat_t;

    function automatic logic idx_ok(input logic [IDX_W-1:0] idx, input int unsigned depth);
        return 32'(idx) < depth;
    endfunction

    function automatic logic opnd_bad(input logic [KIND_W-1:0] kind,
                                      input logic [IDX_W-1:0] idx,
                                      input int unsigned regs,
                                      input int unsigned words);
        logic bad;
        unique case (kind)
            KIND_IMM: bad = 1'b0;
            KIND_MEM: bad = !idx_ok(idx, words);
            KIND_REG: bad = !idx_ok(idx, regs);
            default:  bad = 1'b1;
        endcase
        return bad;
    endfunction

endpackage

>>> rtl/core/ame_in_if.sv
// Instruction channel: valid/ready handshake plus the decoded instruction fields.
// Depends on ame_pkg for field widths.
interface ame_in_if import ame_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [KIND_W-1:0] a_kind;
    logic [IDX_W-1:0]  a_index;
    logic [DATA_W-1:0] a_imm;
    logic [KIND_W-1:0] b_kind;
    logic [IDX_W-1:0]  b_index;
    logic [DATA_W-1:0] b_imm;
    logic [TGT_W-1:0]  target;

    modport source (
        output valid, op, a_kind, a_index, a_imm, b_kind, b_index, b_imm, target,
        input  ready
    );
    modport sink (
        input  valid, op, a_kind, a_index, a_imm, b_kind, b_index, b_imm, target,
        output ready
    );
endinterface

>>> rtl/core/ame_out_if.sv
// Result channel: valid/ready handshake plus one result per instruction.
// Depends on ame_pkg for field widths.
interface ame_out_if import ame_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic              error_sticky;
    logic [DATA_W-1:0] acc_value;
    logic              out_valid;
    logic [DATA_W-1:0] out_value;
    logic              branch_taken;
    logic [TGT_W-1:0]  branch_target;

    modport source (
        output valid, status, error_sticky, acc_value, out_valid, out_value,
               branch_taken, branch_target,
        input  ready
    );
    modport sink (
        input  valid, status, error_sticky, acc_value, out_valid, out_value,
               branch_taken, branch_target,
        output ready
    );
endinterface

>>> rtl/core/ame_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module ame_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/core/ame_front.sv
// Front end: accepts instructions and classifies them (static operand, destination,
// opcode and branch target checks) before queueing. Depends on ame_pkg, ame_in_if.
module ame_front import ame_pkg::*; #(
    parameter int REG_COUNT = REG_COUNT_DEF,
    parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
    ame_in_if.sink     instr,
    input  ame_qstat_t qstat,
    output logic       push,
    output ame_dec_t   dec
);
    logic a_bad;
    logic b_bad;
    logic dst_bad;
    logic bad;

    always_comb
    begin
        a_bad   = opnd_bad(instr.a_kind, instr.a_index, REG_COUNT, MEM_DEPTH);
        b_bad   = opnd_bad(instr.b_kind, instr.b_index, REG_COUNT, MEM_DEPTH);
        // an immediate is never a legal destination
        dst_bad = a_bad || (instr.a_kind == KIND_IMM);

        unique case (instr.op)
            OP_NOP, OP_BRH, OP_BEQ:                  bad = 1'b0;
            OP_MOV:                                  bad = b_bad || dst_bad;
            OP_CMP:                                  bad = a_bad || b_bad;
            OP_OUT, OP_ADD, OP_SUB, OP_MLT, OP_DIV:  bad = a_bad;
            default:                                 bad = 1'b1;
        endcase
    end

    assign instr.ready = !qstat.full;
    assign push        = instr.valid && !qstat.full;

    always_comb
    begin
        dec.op      = instr.op;
        dec.a_kind  = instr.a_kind;
        dec.a_index = instr.a_index;
        dec.a_imm   = instr.a_imm;
        dec.b_kind  = instr.b_kind;
        dec.b_index = instr.b_index;
        dec.b_imm   = instr.b_imm;
        dec.target  = instr.target;
        dec.bad     = bad;
        dec.tgt_ok  = 32'(instr.target) < 32'(PROG_DEPTH);
    end
endmodule

>>> rtl/core/ame_queue.sv
// Short FIFO of classified instructions between front and back end.
// Depends on ame_pkg.
module ame_queue import ame_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ame_dec_t   din,
    input  logic       pop,
    output ame_dec_t   dout,
    output ame_qstat_t qstat
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    ame_dec_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign qstat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign dout        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end
endmodule

>>> rtl/core/ame_div.sv
// Radix-2 restoring divider, signed 32-bit, truncating; one quotient bit per cycle.
// Depends on ame_pkg. Divisor must be nonzero when started.
module ame_div import ame_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DATA_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;

    assign rem_sh = {rem_reg, quo_reg[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W);
            rem_next  = '0;
            // magnitudes; the most negative value maps onto itself as unsigned
            quo_next  = dividend[DATA_W-1] ? -dividend : dividend;
            dvs_next  = divisor[DATA_W-1] ? -divisor : divisor;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -quo_reg : quo_reg;
endmodule

>>> rtl/core/ame_back.sv
// Back end: reads operands from register file and data memory, executes one
// instruction at a time and holds the result for transfer. Depends on ame_pkg,
// ame_out_if, ame_ram, ame_div.
module ame_back import ame_pkg::*; #(
    parameter int REG_COUNT = REG_COUNT_DEF,
    parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  ame_qstat_t qstat,
    input  ame_dec_t   qdata,
    output logic       pop,
    ame_out_if.source  result
);
    localparam int RAW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int MAW = $clog2(MEM_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD_B = 3'd1;
    localparam logic [2:0] S_RD_A = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]           state_reg, state_next;
    ame_dec_t             ins_reg, ins_next;
    logic [DATA_W-1:0]    vb_reg, vb_next;
    logic [DATA_W-1:0]    acc_reg, acc_next;
    logic                 err_reg, err_next;
    logic [REG_COUNT-1:0] rvalid_reg, rvalid_next;
    logic [MEM_DEPTH-1:0] mvalid_reg, mvalid_next;

    // per-instruction working results
    logic                 w_taken_reg, w_taken_next;
    logic [TGT_W-1:0]     w_tgt_reg, w_tgt_next;
    logic                 w_ov_reg, w_ov_next;
    logic [DATA_W-1:0]    w_oval_reg, w_oval_next;
    logic                 w_divz_reg, w_divz_next;

    // output register
    logic                 res_valid_reg, res_valid_next;
    logic [STAT_W-1:0]    res_stat_reg, res_stat_next;
    logic                 res_err_reg, res_err_next;
    logic [DATA_W-1:0]    res_acc_reg, res_acc_next;
    logic                 res_ov_reg, res_ov_next;
    logic [DATA_W-1:0]    res_oval_reg, res_oval_next;
    logic                 res_taken_reg, res_taken_next;
    logic [TGT_W-1:0]     res_tgt_reg, res_tgt_next;

    logic [IDX_W-1:0]     rd_idx;
    logic [31:0]          rd_idx_w;
    logic [31:0]          wr_idx_w;
    logic [31:0]          op_idx_w;
    logic [KIND_W-1:0]    op_kind;
    logic [IDX_W-1:0]     op_idx;
    logic [DATA_W-1:0]    op_imm;
    logic [DATA_W-1:0]    op_val;
    logic [DATA_W-1:0]    reg_rdata;
    logic [DATA_W-1:0]    mem_rdata;
    logic                 reg_we;
    logic                 mem_we;
    logic [2*DATA_W-1:0]  prod;
    logic                 div_start;
    logic                 div_done;
    logic [DATA_W-1:0]    div_quo;
    logic                 out_free;

    assign rd_idx   = (state_reg == S_RD_B) ? ins_reg.b_index : ins_reg.a_index;
    assign rd_idx_w = 32'(rd_idx);
    assign wr_idx_w = 32'(ins_reg.a_index);

    ame_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_reg_ram (
        .clk   (clk),
        .we    (reg_we),
        .waddr (wr_idx_w[RAW-1:0]),
        .wdata (vb_reg),
        .raddr (rd_idx_w[RAW-1:0]),
        .rdata (reg_rdata)
    );

    ame_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_mem_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_idx_w[MAW-1:0]),
        .wdata (vb_reg),
        .raddr (rd_idx_w[MAW-1:0]),
        .rdata (mem_rdata)
    );

    ame_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (op_val),
        .done     (div_done),
        .quotient (div_quo)
    );

    // RAM data of b arrives in S_RD_A, data of a in S_EXEC
    always_comb
    begin
        if (state_reg == S_RD_A)
        begin
            op_kind = ins_reg.b_kind;
            op_idx  = ins_reg.b_index;
            op_imm  = ins_reg.b_imm;
        end
        else
        begin
            op_kind = ins_reg.a_kind;
            op_idx  = ins_reg.a_index;
            op_imm  = ins_reg.a_imm;
        end
        op_idx_w = 32'(op_idx);

        unique case (op_kind)
            KIND_IMM:
            begin
                op_val = op_imm;
            end
            KIND_MEM:
            begin
                op_val = (idx_ok(op_idx, MEM_DEPTH) && mvalid_reg[op_idx_w[MAW-1:0]])
                         ? mem_rdata : '0;
            end
            KIND_REG:
            begin
                if (!idx_ok(op_idx, REG_COUNT))
                begin
                    op_val = '0;
                end
                else if (op_idx == '0)
                begin
                    op_val = acc_reg;
                end
                else
                begin
                    op_val = rvalid_reg[op_idx_w[RAW-1:0]] ? reg_rdata : '0;
                end
            end
            default:
            begin
                op_val = '0;
            end
        endcase
    end

    assign prod     = acc_reg * op_val;
    assign out_free = !res_valid_reg || result.ready;

    always_comb
    begin
        state_next   = state_reg;
        ins_next     = ins_reg;
        vb_next      = vb_reg;
        acc_next     = acc_reg;
        err_next     = err_reg;
        rvalid_next  = rvalid_reg;
        mvalid_next  = mvalid_reg;
        w_taken_next = w_taken_reg;
        w_tgt_next   = w_tgt_reg;
        w_ov_next    = w_ov_reg;
        w_oval_next  = w_oval_reg;
        w_divz_next  = w_divz_reg;
        pop          = 1'b0;
        reg_we       = 1'b0;
        mem_we       = 1'b0;
        div_start    = 1'b0;

        res_valid_next = res_valid_reg && !result.ready;
        res_stat_next  = res_stat_reg;
        res_err_next   = res_err_reg;
        res_acc_next   = res_acc_reg;
        res_ov_next    = res_ov_reg;
        res_oval_next  = res_oval_reg;
        res_taken_next = res_taken_reg;
        res_tgt_next   = res_tgt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    ins_next   = qdata;
                    state_next = S_RD_B;
                end
            end
            S_RD_B:
            begin
                state_next = S_RD_A;
            end
            S_RD_A:
            begin
                vb_next    = op_val;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                w_taken_next = 1'b0;
                w_tgt_next   = '0;
                w_ov_next    = 1'b0;
                w_oval_next  = '0;
                w_divz_next  = 1'b0;
                err_next     = err_reg || ins_reg.bad;
                state_next   = S_DONE;
                unique case (ins_reg.op)
                    OP_MOV:
                    begin
                        if (ins_reg.a_kind == KIND_MEM && idx_ok(ins_reg.a_index, MEM_DEPTH))
                        begin
                            mem_we = 1'b1;
                            mvalid_next[wr_idx_w[MAW-1:0]] = 1'b1;
                        end
                        else if (ins_reg.a_kind == KIND_REG
                                 && idx_ok(ins_reg.a_index, REG_COUNT))
                        begin
                            if (ins_reg.a_index == '0)
                            begin
                                acc_next = vb_reg;
                            end
                            else
                            begin
                                reg_we = 1'b1;
                                rvalid_next[wr_idx_w[RAW-1:0]] = 1'b1;
                            end
                        end
                    end
                    OP_CMP:
                    begin
                        if (op_val == vb_reg)
                        begin
                            acc_next = '0;
                        end
                        else if ($signed(op_val) > $signed(vb_reg))
                        begin
                            acc_next = DATA_W'(1);
                        end
                        else
                        begin
                            acc_next = '1;
                        end
                    end
                    OP_BRH, OP_BEQ:
                    begin
                        if (ins_reg.tgt_ok && (ins_reg.op == OP_BRH || acc_reg == '0))
                        begin
                            w_taken_next = 1'b1;
                            w_tgt_next   = ins_reg.target;
                        end
                    end
                    OP_OUT:
                    begin
                        w_ov_next   = 1'b1;
                        w_oval_next = op_val;
                    end
                    OP_ADD:
                    begin
                        acc_next = acc_reg + op_val;
                    end
                    OP_SUB:
                    begin
                        acc_next = acc_reg - op_val;
                    end
                    OP_MLT:
                    begin
                        acc_next = prod[DATA_W-1:0];
                    end
                    OP_DIV:
                    begin
                        if (op_val == '0)
                        begin
                            w_divz_next = 1'b1;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    acc_next   = div_quo;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    if (ins_reg.bad)
                    begin
                        res_stat_next = STAT_BAD;
                    end
                    else if (w_divz_reg)
                    begin
                        res_stat_next = STAT_DIVZ;
                    end
                    else
                    begin
                        res_stat_next = STAT_OK;
                    end
                    res_err_next   = err_reg;
                    res_acc_next   = acc_reg;
                    res_ov_next    = w_ov_reg;
                    res_oval_next  = w_oval_reg;
                    res_taken_next = w_taken_reg;
                    res_tgt_next   = w_tgt_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            err_reg       <= 1'b0;
            rvalid_reg    <= '0;
            mvalid_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            err_reg       <= err_next;
            rvalid_reg    <= rvalid_next;
            mvalid_reg    <= mvalid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg       <= ins_next;
        vb_reg        <= vb_next;
        w_taken_reg   <= w_taken_next;
        w_tgt_reg     <= w_tgt_next;
        w_ov_reg      <= w_ov_next;
        w_oval_reg    <= w_oval_next;
        w_divz_reg    <= w_divz_next;
        res_stat_reg  <= res_stat_next;
        res_err_reg   <= res_err_next;
        res_acc_reg   <= res_acc_next;
        res_ov_reg    <= res_ov_next;
        res_oval_reg  <= res_oval_next;
        res_taken_reg <= res_taken_next;
        res_tgt_reg   <= res_tgt_next;
    end

    assign result.valid         = res_valid_reg;
    assign result.status        = res_stat_reg;
    assign result.error_sticky  = res_err_reg;
    assign result.acc_value     = res_acc_reg;
    assign result.out_valid     = res_ov_reg;
    assign result.out_value     = res_oval_reg;
    assign result.branch_taken  = res_taken_reg;
    assign result.branch_target = res_tgt_reg;
endmodule

>>> rtl/core/accumulator_machine_execute.sv
// Top level of the accumulator machine execute block: front end, queue, back end.
// Depends on ame_pkg, ame_in_if, ame_out_if, ame_front, ame_queue, ame_back.
//
// Executes one pre-decoded instruction per input transfer and returns exactly one
// result transfer for it, in order. The register file and data memory are cleared
// at reset (per-entry valid bits, no clearing pass), so the block is ready as soon
// as reset is released. The front end classifies each instruction and queues up
// to two of them, so input transfers continue while the back end is busy or a
// result waits to be taken. The back end runs one instruction at a time through
// dequeue, two operand reads through the registered RAM ports, execute and result
// load; a DIV with a nonzero divisor also waits on the radix-2 divider, which
// produces one quotient bit per cycle.
module accumulator_machine_execute import ame_pkg::*; #(
    parameter int REG_COUNT = REG_COUNT_DEF,
    parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ame_in_if.sink    instr,
    ame_out_if.source result
);
    ame_dec_t   push_data;
    ame_dec_t   pop_data;
    ame_qstat_t qstat;
    logic       push;
    logic       pop;

    ame_front #(.REG_COUNT(REG_COUNT), .MEM_DEPTH(MEM_DEPTH)) u_front (
        .instr (instr),
        .qstat (qstat),
        .push  (push),
        .dec   (push_data)
    );

    ame_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_data),
        .pop   (pop),
        .dout  (pop_data),
        .qstat (qstat)
    );

    ame_back #(.REG_COUNT(REG_COUNT), .MEM_DEPTH(MEM_DEPTH)) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qstat  (qstat),
        .qdata  (pop_data),
        .pop    (pop),
        .result (result)
    );
endmodule

>>> dv/tb_accumulator_machine_execute.sv
// Self-checking testbench for accumulator_machine_execute: a directed table and then
// random instruction streams, each result checked against a hand-written value or an in-bench execution model.
// Depends on ame_pkg, ame_in_if, ame_out_if and the RTL under rtl/core.
module tb_accumulator_machine_execute;
    import ame_pkg::*;

    localparam logic [KIND_W-1:0] KIND_BAD  = 2'd3;
    localparam logic [OP_W-1:0]   OP_UNUSED = 4'd15;
    localparam logic [DATA_W-1:0] INT_MIN   = 32'h8000_0000;
    localparam logic [DATA_W-1:0] INT_MAX   = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] ALL_ONES  = 32'hffff_ffff;

    localparam int RANDOM_INSTRS = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 60;
    localparam int STALL_LIMIT   = 4000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KIND_W-1:0] a_kind;
        logic [IDX_W-1:0]  a_index;
        logic [DATA_W-1:0] a_imm;
        logic [KIND_W-1:0] b_kind;
        logic [IDX_W-1:0]  b_index;
        logic [DATA_W-1:0] b_imm;
        logic [TGT_W-1:0]  target;
    } instr_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              error_sticky;
        logic [DATA_W-1:0] acc_value;
        logic              out_valid;
        logic [DATA_W-1:0] out_value;
        logic              branch_taken;
        logic [TGT_W-1:0]  branch_target;
    } result_t;

    typedef struct {
        instr_t  ins;
        bit      typed;
        result_t res;
    } dir_row_t;

    localparam result_t NO_RES = '0;
    localparam int DIR_ROWS = 26;

    // Rows with typed = 1 carry a hand-written result; the rest go through the model.
    dir_row_t dir_tab [DIR_ROWS] = '{
        // reads right after reset
        '{'{OP_OUT, KIND_REG, 6'd0, 32'd0, KIND_IMM, 6'd0, 32'd0, 10'd0}, 1'b1,
          '{STAT_OK, 1'b0, 32'd0, 1'b1, 32'd0, 1'b0, 10'd0}},
        '{'{OP_OUT, KIND_MEM, 6'd63, 32'd0, KIND_IMM, 6'd0, 32'd0, 10'd0}, 1'b1,
          '{STAT_OK, 1'b0, 32'd0, 1'b1, 32'd0, 1'b0, 10'd0}},
        '{'{OP_BRH, KIND_IMM, 6'd0, 32'd0, KIND_IMM, 6'd0, 32'd0, 10'd1023}, 1'b1,
          '{STAT_OK, 1'b0, 32'd0, 1'b0, 32'd0, 1'b1, 10'd1023}},
        '{'{OP_BEQ, KIND_IMM, 6'd0, 32'd0, KIND_IMM, 6'd0, 32'd0, 10'd0}, 1'b1,
          '{STAT_OK, 1'b0, 32'd0, 1'b0, 32'd0, 1'b1, 10'd0}},
        '{'{OP_DIV, KIND_IMM, 6'd0, 32'd0, KIND_IMM, 6'd0, 32'd0, 10'd0}, 1'b1,
          '{STAT_DIVZ, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 10'd0}},
        '{'{OP_MOV, KIND_REG, 6'd0, 32'd0, KIND_IMM, 6'd0, INT_MIN, 10'd0}, 1'b1,
          '{STAT_OK, 1'b0, INT_MIN, 1'b0, 32'd0, 1'b0, 10'd0}},
        // INT_MIN / -1 wraps
        '{'{OP_DIV, KIND_IMM, 6'd0, ALL_ONES, KIND_IMM, 6'd0, 32'd0, 10'd0}, 1'b1,
          '{STAT_OK, 1'b0, INT_MIN, 1'b0, 32'd0, 1'b0, 10'd0}},
        '{'{OP_MOV, KIND_MEM, 6'd63, 32'd0, KIND_IMM, 6'd0, INT_MAX, 10'd0}, 1'b0, NO_RES},
        '{'{OP_MOV, KIND_REG, 6'd18, 32'd0, KIND_MEM, 6'd63, 32'd0, 10'd0}, 1'b0, NO_RES},
        '{'{OP_CMP, KIND_REG, 6'd18, 32'd0, KIND_IMM, 6'd0, INT_MIN, 10'd0}, 1'b0, NO_RES},
        '{'{OP_CMP, KIND_IMM, 6'd0, INT_MIN, KIND_REG, 6'd18, 32'd0, 10'd0}, 1'b0, NO_RES},
        '{'{OP_CMP, KIND_IMM, 6'd0, 32'd5, KIND_IMM, 6'd0, 32'd5, 10'd0}, 1'b0, NO_RES},
        '{'{OP_OUT, KIND_IMM, 6'd0, ALL_ONES, KIND_IMM, 6'd0, 32'd0, 10'd0}, 1'b0, NO_RES},
        '{'{OP_ADD, KIND_REG, 6'd18, 32'd0, KIND_IMM, 6'd0, 32'd0, 10'd0}, 1'b0, NO_RES},
        '{'{OP_ADD, KIND_IMM, 6'd0, 32'd1, KIND_IMM, 6'd0, 32'd0, 10'd0}, 1'b0, NO_RES},
        '{'{OP_SUB, KIND_MEM, 6'd63, 32'd0, KIND_IMM, 6'd0, 32'd0, 10'd0}, 1'b0, NO_RES},
        '{'{OP_MLT, KIND_IMM, 6'd0, ALL_ONES, KIND_IMM, 6'd0, 32'd0, 10'd0}, 1'b0, NO_RES},
        '{'{OP_DIV, KIND_IMM, 6'd0, 32'd7, KIND_IMM, 6'd0, 32'd0, 10'd0}, 1'b0, NO_RES},
        '{'{OP_NOP, KIND_BAD, 6'd63, ALL_ONES, KIND_BAD, 6'd63, ALL_ONES, 10'd1023},
          1'b0, NO_RES},
        // error cases, sticky flag from here on
        '{'{OP_MOV, KIND_IMM, 6'd0, 32'd1, KIND_IMM, 6'd0, 32'd3, 10'd0}, 1'b0, NO_RES},
        '{'{OP_OUT, KIND_REG, 6'd19, 32'd0, KIND_IMM, 6'd0, 32'd0, 10'd0}, 1'b0, NO_RES},
        '{'{OP_ADD, KIND_BAD, 6'd0, 32'd9, KIND_IMM, 6'd0, 32'd0, 10'd0}, 1'b0, NO_RES},
        '{'{OP_DIV, KIND_BAD, 6'd0, 32'd9, KIND_IMM, 6'd0, 32'd0, 10'd0}, 1'b0, NO_RES},
        '{'{OP_UNUSED, KIND_IMM, 6'd0, 32'd0, KIND_IMM, 6'd0, 32'd0, 10'd0}, 1'b0, NO_RES},
        '{'{OP_MOV, KIND_REG, 6'd63, 32'd0, KIND_REG, 6'd18, 32'd0, 10'd0}, 1'b0, NO_RES},
        '{'{OP_MOV, KIND_MEM, 6'd0, 32'd0, KIND_REG, 6'd40, 32'd0, 10'd0}, 1'b0, NO_RES}
    };

    logic clk;
    logic rst_n;

    ame_in_if  instr_if ();
    ame_out_if result_if ();

    accumulator_machine_execute dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_if),
        .result (result_if)
    );

    // execution model state
    logic [DATA_W-1:0] mach_reg [REG_COUNT_DEF];
    logic [DATA_W-1:0] mach_mem [MEM_DEPTH_DEF];
    bit                mach_err;

    result_t pending_results [$];
    int      mismatch_count;
    bit      calm;
    bit      hold_req;
    int      idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [DATA_W-1:0] fetch_operand(input logic [KIND_W-1:0] kind,
                                                        input logic [IDX_W-1:0] idx,
                                                        input logic [DATA_W-1:0] imm,
                                                        inout bit bad);
        logic [DATA_W-1:0] v;
        v = '0;
        case (kind)
            KIND_IMM: v = imm;
            KIND_MEM:
                if (idx < MEM_DEPTH_DEF) v = mach_mem[idx];
                else bad = 1'b1;
            KIND_REG:
                if (idx < REG_COUNT_DEF) v = mach_reg[idx];
                else bad = 1'b1;
            default: bad = 1'b1;
        endcase
        return v;
    endfunction

    function automatic result_t execute_instr(input instr_t it);
        result_t           r;
        bit                bad;
        bit                divz;
        logic [DATA_W-1:0] va;
        logic [DATA_W-1:0] vb;
        logic [63:0]       wide;
        longint            quot;
        r = '0;
        bad = 1'b0;
        divz = 1'b0;
        case (it.op)
            OP_NOP: ;
            OP_MOV:
            begin
                vb = fetch_operand(it.b_kind, it.b_index, it.b_imm, bad);
                if (it.a_kind == KIND_MEM && it.a_index < MEM_DEPTH_DEF)
                    mach_mem[it.a_index] = vb;
                else if (it.a_kind == KIND_REG && it.a_index < REG_COUNT_DEF)
                    mach_reg[it.a_index] = vb;
                else
                    bad = 1'b1;
            end
            OP_CMP:
            begin
                vb = fetch_operand(it.b_kind, it.b_index, it.b_imm, bad);
                va = fetch_operand(it.a_kind, it.a_index, it.a_imm, bad);
                if ($signed(va) == $signed(vb))
                    mach_reg[0] = '0;
                else if ($signed(va) > $signed(vb))
                    mach_reg[0] = 32'd1;
                else
                    mach_reg[0] = ALL_ONES;
            end
            OP_BRH, OP_BEQ:
            begin
                if ((it.op == OP_BRH || mach_reg[0] == '0) && it.target < PROG_DEPTH)
                begin
                    r.branch_taken = 1'b1;
                    r.branch_target = it.target;
                end
            end
            OP_OUT:
            begin
                r.out_value = fetch_operand(it.a_kind, it.a_index, it.a_imm, bad);
                r.out_valid = 1'b1;
            end
            OP_ADD:
            begin
                va = fetch_operand(it.a_kind, it.a_index, it.a_imm, bad);
                mach_reg[0] = mach_reg[0] + va;
            end
            OP_SUB:
            begin
                va = fetch_operand(it.a_kind, it.a_index, it.a_imm, bad);
                mach_reg[0] = mach_reg[0] - va;
            end
            OP_MLT:
            begin
                va = fetch_operand(it.a_kind, it.a_index, it.a_imm, bad);
                wide = 64'(mach_reg[0]) * 64'(va);
                mach_reg[0] = wide[31:0];
            end
            OP_DIV:
            begin
                va = fetch_operand(it.a_kind, it.a_index, it.a_imm, bad);
                if (va == '0)
                    divz = 1'b1;
                else
                begin
                    // 64-bit quotient so that INT_MIN / -1 wraps cleanly
                    quot = longint'($signed(mach_reg[0])) / longint'($signed(va));
                    mach_reg[0] = quot[31:0];
                end
            end
            default: bad = 1'b1;
        endcase
        if (bad)
            mach_err = 1'b1;
        r.status = bad ? STAT_BAD : (divz ? STAT_DIVZ : STAT_OK);
        r.error_sticky = mach_err;
        r.acc_value = mach_reg[0];
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return '0;
            1: return 32'd1;
            2: return ALL_ONES;
            3: return INT_MIN;
            4: return INT_MAX;
            5, 6: return 32'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    task automatic pick_operand(output logic [KIND_W-1:0] kind,
                                output logic [IDX_W-1:0] idx,
                                output logic [DATA_W-1:0] imm);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            kind = KIND_BAD;
        else if (sel <= 6)
            kind = KIND_IMM;
        else if (sel <= 12)
            kind = KIND_MEM;
        else
            kind = KIND_REG;
        // registers mostly in range, now and then past the end of the file
        if (kind == KIND_REG && $urandom_range(0, 9) != 0)
            idx = IDX_W'($urandom_range(0, REG_COUNT_DEF - 1));
        else
            idx = IDX_W'($urandom_range(0, 63));
        imm = pick_value();
    endtask

    task automatic pick_instr(output instr_t it);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)       it.op = OP_MOV;
        else if (sel < 25)  it.op = OP_CMP;
        else if (sel < 30)  it.op = OP_BRH;
        else if (sel < 38)  it.op = OP_BEQ;
        else if (sel < 45)  it.op = OP_OUT;
        else if (sel < 57)  it.op = OP_ADD;
        else if (sel < 67)  it.op = OP_SUB;
        else if (sel < 77)  it.op = OP_MLT;
        else if (sel < 94)  it.op = OP_DIV;
        else if (sel < 97)  it.op = OP_NOP;
        else                it.op = OP_W'($urandom_range(10, 15));
        pick_operand(it.a_kind, it.a_index, it.a_imm);
        pick_operand(it.b_kind, it.b_index, it.b_imm);
        it.target = TGT_W'($urandom_range(0, 1023));
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatch_count++;
        $display("mismatch %s: got 0x%08h, expected 0x%08h", what, got, want);
    endtask

    // called just after the clock rises; returns once the instruction has been taken
    task automatic send_instr(input instr_t it, input bit typed, input result_t fixed);
        result_t pred;
        instr_if.valid   <= 1'b1;
        instr_if.op      <= it.op;
        instr_if.a_kind  <= it.a_kind;
        instr_if.a_index <= it.a_index;
        instr_if.a_imm   <= it.a_imm;
        instr_if.b_kind  <= it.b_kind;
        instr_if.b_index <= it.b_index;
        instr_if.b_imm   <= it.b_imm;
        instr_if.target  <= it.target;
        do @(posedge clk); while (!instr_if.ready);
        pred = execute_instr(it);
        pending_results.push_back(typed ? fixed : pred);
    endtask

    task automatic sender_gap();
        while (!calm && $urandom_range(0, 99) < 25)
        begin
            instr_if.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_results_done();
        instr_if.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    initial
    begin
        instr_t it;
        rst_n            <= 1'b0;
        instr_if.valid   <= 1'b0;
        instr_if.op      <= OP_NOP;
        instr_if.a_kind  <= KIND_IMM;
        instr_if.a_index <= '0;
        instr_if.a_imm   <= '0;
        instr_if.b_kind  <= KIND_IMM;
        instr_if.b_index <= '0;
        instr_if.b_imm   <= '0;
        instr_if.target  <= '0;
        mismatch_count = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        mach_err = 1'b0;
        foreach (mach_reg[i]) mach_reg[i] = '0;
        foreach (mach_mem[i]) mach_mem[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_instr(dir_tab[i].ins, dir_tab[i].typed, dir_tab[i].res);
            sender_gap();
        end
        wait_results_done();

        for (int n = 0; n < RANDOM_INSTRS; n++)
        begin
            if (n == 300 || n == 1500)
                hold_req = 1'b1;
            if (n == 1200)
                wait_results_done();
            calm = (n >= 600 && n < 900);
            pick_instr(it);
            send_instr(it, 1'b0, NO_RES);
            sender_gap();
        end
        calm = 1'b0;
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
            report_mismatch("results missing at end", 32'(pending_results.size()), '0);
        if (mismatch_count == 0)
            $display("[accumulator_machine_execute] OK");
        else
            $display("[accumulator_machine_execute] ERROR");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        result_if.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_req)
            begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                result_if.ready <= calm || ($urandom_range(0, 99) >= 25);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got.status        = result_if.status;
            got.error_sticky  = result_if.error_sticky;
            got.acc_value     = result_if.acc_value;
            got.out_valid     = result_if.out_valid;
            got.out_value     = result_if.out_value;
            got.branch_taken  = result_if.branch_taken;
            got.branch_target = result_if.branch_target;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, acc_value", got.acc_value, '0);
            else
            begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.error_sticky != want.error_sticky)
                    report_mismatch("error_sticky", 32'(got.error_sticky),
                                    32'(want.error_sticky));
                if (got.acc_value != want.acc_value)
                    report_mismatch("acc_value", got.acc_value, want.acc_value);
                if (got.out_valid != want.out_valid)
                    report_mismatch("out_valid", 32'(got.out_valid), 32'(want.out_valid));
                if (got.out_value != want.out_value)
                    report_mismatch("out_value", got.out_value, want.out_value);
                if (got.branch_taken != want.branch_taken)
                    report_mismatch("branch_taken", 32'(got.branch_taken),
                                    32'(want.branch_taken));
                if (got.branch_target != want.branch_target)
                    report_mismatch("branch_target", 32'(got.branch_target),
                                    32'(want.branch_target));
            end
        end
    end

    // watchdog: cycles without any transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (instr_if.valid && instr_if.ready) ||
            (result_if.valid && result_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[accumulator_machine_execute] ERROR");
            $finish;
        end
    end

endmodule
